// File: rtl/core/srd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package srd_pkg;

    localparam int ADDR_BITS_DEF = 20;
    localparam int ROW_W = 16;
    localparam int COL_W = 17;
    localparam int CNT_W = 6;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    localparam int CFG_AW = 5;

    localparam logic [2:0] REG_MODE   = 3'd0;
    localparam logic [2:0] REG_WIDTH  = 3'd1;
    localparam logic [2:0] REG_HEIGHT = 3'd2;
    localparam logic [2:0] REG_DEST_W = 3'd3;
    localparam logic [2:0] REG_COL_B  = 3'd4;
    localparam logic [2:0] REG_ROW_B  = 3'd5;
    localparam logic [2:0] REG_TRANSP = 3'd6;

    typedef struct packed {
        logic        compressed_mode;
        logic [15:0] frame_width;
        logic [15:0] frame_height;
        logic [15:0] dest_width;
        logic [15:0] col_base;
        logic [15:0] row_base;
        logic [7:0]  transparent_index;
    } t_cfg;

    typedef struct packed {
        logic             we;
        logic [CNT_W-1:0] cnt_m1;
        logic [7:0]       value;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             fdone;
    } t_cmd;

endpackage

`default_nettype wire

// File: rtl/core/srd_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface srd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_start;

    modport source (output valid, output data_byte, output frame_start, input ready);
    modport sink (input valid, input data_byte, input frame_start, output ready);
endinterface

interface srd_pix_if #(
    parameter int ADDR_BITS = srd_pkg::ADDR_BITS_DEF
);
    logic                 valid;
    logic                 ready;
    logic                 write_enable;
    logic [ADDR_BITS-1:0] pixel_addr;
    logic [7:0]           pixel_value;
    logic                 last_of_run;
    logic                 frame_done;

    modport source (
        output valid, output write_enable, output pixel_addr, output pixel_value,
        output last_of_run, output frame_done, input ready
    );
    modport sink (
        input valid, input write_enable, input pixel_addr, input pixel_value,
        input last_of_run, input frame_done, output ready
    );
endinterface

`default_nettype wire

// File: rtl/core/srd_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module srd_queue (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  srd_pkg::t_cmd     i_cmd,
    input  wire logic         i_pop,
    output srd_pkg::t_cmd     o_cmd,
    output logic              o_empty,
    output logic              o_full
);
    import srd_pkg::*;

    t_cmd               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr;
    logic [Q_PTR_W-1:0] r_rd;
    logic [Q_CNT_W-1:0] r_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/srd_front.sv
`timescale 1ns / 1ps
`default_nettype none

module srd_front (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    srd_byte_if.sink          i_byte,
    input  srd_pkg::t_cfg     i_cfg,
    input  wire logic         i_q_full,
    output logic              o_q_push,
    output srd_pkg::t_cmd     o_q_cmd
);
    import srd_pkg::*;

    localparam logic [2:0] PH_CNT_LO = 3'd0;
    localparam logic [2:0] PH_CNT_HI = 3'd1;
    localparam logic [2:0] PH_MASK   = 3'd2;
    localparam logic [2:0] PH_REPVAL = 3'd3;
    localparam logic [2:0] PH_LIT    = 3'd4;

    logic [2:0]       r_phase, n_phase, e_phase;
    logic [ROW_W-1:0] r_row, n_row, e_row;
    logic [COL_W-1:0] r_col, n_col, e_col;
    logic [15:0]      r_total, n_total, e_total;
    logic [16:0]      r_used, n_used, e_used;
    logic [6:0]       r_lit, n_lit, e_lit;
    logic [CNT_W-1:0] r_rep, n_rep, e_rep;
    logic             r_done, n_done, e_done;

    logic       w_accept;
    logic       w_fdone;
    logic       w_token_done;
    logic       w_end_row;
    logic [7:0] w_b;
    logic [7:0] w_v;
    t_cmd       w_cmd;

    assign i_byte.ready = ~i_q_full;
    assign w_accept     = i_byte.valid & ~i_q_full;
    assign o_q_push     = w_accept;
    assign o_q_cmd      = w_cmd;
    assign w_b          = i_byte.data_byte;
    assign w_v          = (w_b == i_cfg.transparent_index) ? 8'd0 : w_b;

    always_comb begin
        e_phase = r_phase;
        e_row   = r_row;
        e_col   = r_col;
        e_total = r_total;
        e_used  = r_used;
        e_lit   = r_lit;
        e_rep   = r_rep;
        e_done  = r_done;
        w_fdone = 1'b0;

        if (i_byte.frame_start) begin
            e_phase = PH_CNT_LO;
            e_row   = '0;
            e_col   = '0;
            e_total = '0;
            e_used  = '0;
            e_lit   = '0;
            e_rep   = '0;
            e_done  = 1'b0;
            if (i_cfg.frame_height == '0
                || (!i_cfg.compressed_mode && i_cfg.frame_width == '0)) begin
                e_done  = 1'b1;
                w_fdone = 1'b1;
            end
        end
        if (!e_done && e_row >= i_cfg.frame_height) begin
            e_done = 1'b1;
        end

        n_phase = e_phase;
        n_row   = e_row;
        n_col   = e_col;
        n_total = e_total;
        n_used  = e_used;
        n_lit   = e_lit;
        n_rep   = e_rep;
        n_done  = e_done;

        w_cmd        = '0;
        w_cmd.row    = e_row;
        w_cmd.col    = e_col;
        w_token_done = 1'b0;
        w_end_row    = 1'b0;

        if (!e_done) begin
            if (!i_cfg.compressed_mode) begin
                w_cmd.we    = 1'b1;
                w_cmd.value = w_b;
                n_col       = e_col + 1'b1;
                if (n_col >= {1'b0, i_cfg.frame_width}) begin
                    w_end_row = 1'b1;
                end
            end else begin
                case (e_phase)
                    PH_CNT_LO: begin
                        n_total = {8'd0, w_b};
                        n_phase = PH_CNT_HI;
                    end
                    PH_CNT_HI: begin
                        n_total      = {w_b, e_total[7:0]};
                        n_used       = '0;
                        n_phase      = PH_MASK;
                        w_token_done = 1'b1;
                    end
                    PH_MASK: begin
                        n_used = e_used + 1'b1;
                        if (w_b[0]) begin
                            n_col        = e_col + COL_W'(w_b[7:1]);
                            w_token_done = 1'b1;
                        end else if (w_b[1]) begin
                            n_rep   = w_b[7:2];
                            n_phase = PH_REPVAL;
                        end else begin
                            n_lit   = {1'b0, w_b[7:2]} + 7'd1;
                            n_phase = PH_LIT;
                        end
                    end
                    PH_REPVAL: begin
                        n_used       = e_used + 1'b1;
                        w_cmd.we     = 1'b1;
                        w_cmd.value  = w_v;
                        w_cmd.cnt_m1 = e_rep;
                        n_col        = e_col + COL_W'(e_rep) + 1'b1;
                        n_phase      = PH_MASK;
                        w_token_done = 1'b1;
                    end
                    default: begin
                        n_used      = e_used + 1'b1;
                        w_cmd.we    = 1'b1;
                        w_cmd.value = w_v;
                        n_col       = e_col + 1'b1;
                        if (e_lit != '0) begin
                            n_lit = e_lit - 1'b1;
                        end
                        if (n_lit == '0) begin
                            n_phase      = PH_MASK;
                            w_token_done = 1'b1;
                        end
                    end
                endcase
                if (w_token_done && n_used >= {1'b0, n_total}) begin
                    w_end_row = 1'b1;
                end
            end

            if (w_end_row) begin
                n_row   = e_row + 1'b1;
                n_col   = '0;
                n_phase = PH_CNT_LO;
                n_used  = '0;
                n_total = '0;
                if (n_row >= i_cfg.frame_height) begin
                    n_done  = 1'b1;
                    w_fdone = 1'b1;
                end
            end
        end

        w_cmd.fdone = w_fdone;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_CNT_LO;
            r_row   <= '0;
            r_col   <= '0;
            r_total <= '0;
            r_used  <= '0;
            r_lit   <= '0;
            r_rep   <= '0;
            r_done  <= 1'b0;
        end else if (w_accept) begin
            r_phase <= n_phase;
            r_row   <= n_row;
            r_col   <= n_col;
            r_total <= n_total;
            r_used  <= n_used;
            r_lit   <= n_lit;
            r_rep   <= n_rep;
            r_done  <= n_done;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/srd_back.sv
`timescale 1ns / 1ps
`default_nettype none

module srd_back #(
    parameter int ADDR_BITS = srd_pkg::ADDR_BITS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  srd_pkg::t_cfg     i_cfg,
    input  wire logic         i_q_empty,
    input  srd_pkg::t_cmd     i_q_cmd,
    output logic              o_q_pop,
    srd_pix_if.source         o_pix
);
    import srd_pkg::*;

    logic [16:0]          w_rsum;
    logic [32:0]          w_prod;
    logic                 w_s2_last;
    logic                 w_s2_take;
    logic                 w_s2_free;
    logic                 w_s1_free;

    logic                 r_s1_valid;
    t_cmd                 r_s1_cmd;
    logic [ADDR_BITS-1:0] r_s1_prod;

    logic                 r_s2_valid;
    logic                 r_s2_we;
    logic [CNT_W-1:0]     r_s2_left;
    logic [7:0]           r_s2_value;
    logic [COL_W-1:0]     r_s2_col;
    logic [ADDR_BITS-1:0] r_s2_base;
    logic                 r_s2_fdone;

    assign w_rsum = {1'b0, i_cfg.row_base} + {1'b0, i_q_cmd.row};
    assign w_prod = w_rsum * i_cfg.dest_width;

    assign w_s2_last = (r_s2_left == '0);
    assign w_s2_take = r_s2_valid & o_pix.ready;
    assign w_s2_free = ~r_s2_valid | (w_s2_take & w_s2_last);
    assign w_s1_free = ~r_s1_valid | w_s2_free;
    assign o_q_pop   = w_s1_free & ~i_q_empty;

    assign o_pix.valid        = r_s2_valid;
    assign o_pix.write_enable = r_s2_we;
    assign o_pix.pixel_addr   = r_s2_we ? (r_s2_base + ADDR_BITS'(r_s2_col)) : '0;
    assign o_pix.pixel_value  = r_s2_value;
    assign o_pix.last_of_run  = w_s2_last;
    assign o_pix.frame_done   = r_s2_fdone & w_s2_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (w_s1_free) begin
                r_s1_valid <= ~i_q_empty;
            end
            if (w_s2_free) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_s1_cmd  <= i_q_cmd;
            r_s1_prod <= w_prod[ADDR_BITS-1:0];
        end
        if (w_s2_free && r_s1_valid) begin
            r_s2_we    <= r_s1_cmd.we;
            r_s2_left  <= r_s1_cmd.cnt_m1;
            r_s2_value <= r_s1_cmd.value;
            r_s2_col   <= r_s1_cmd.col;
            r_s2_base  <= r_s1_prod + ADDR_BITS'(i_cfg.col_base);
            r_s2_fdone <= r_s1_cmd.fdone;
        end else if (w_s2_take && !w_s2_last) begin
            r_s2_left <= r_s2_left - 1'b1;
            r_s2_col  <= r_s2_col + 1'b1;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/sprite_rle_row_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// A byte is accepted whenever the four-entry command queue has room.
// Its command passes through the queue and the registered stages s1 and s2 before it reaches the output.
// A byte that writes n pixels is put out as n transfers, up to 64 for a repeat run.
// The synchronous active-low reset clears the decoder state, the queue and the
// output stages, and returns every configuration register to its reset value.

module sprite_rle_row_decoder #(
    parameter int ADDR_BITS = srd_pkg::ADDR_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    srd_byte_if.sink                         i_byte,
    srd_pix_if.source                        o_pix,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [srd_pkg::CFG_AW-1:0]  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready
);
    import srd_pkg::*;

    t_cfg       r_cfg;
    logic [2:0] w_idx;
    logic       w_wr;
    logic       w_push;
    logic       w_pop;
    logic       w_empty;
    logic       w_full;
    t_cmd       w_push_cmd;
    t_cmd       w_head_cmd;

    assign pready = 1'b1;
    assign w_idx  = paddr[4:2];
    assign w_wr   = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.compressed_mode   <= 1'b1;
            r_cfg.frame_width       <= '0;
            r_cfg.frame_height      <= '0;
            r_cfg.dest_width        <= 16'd1;
            r_cfg.col_base          <= '0;
            r_cfg.row_base          <= '0;
            r_cfg.transparent_index <= 8'd9;
        end else if (w_wr) begin
            case (w_idx)
                REG_MODE:   r_cfg.compressed_mode   <= pwdata[0];
                REG_WIDTH:  r_cfg.frame_width       <= pwdata[15:0];
                REG_HEIGHT: r_cfg.frame_height      <= pwdata[15:0];
                REG_DEST_W: r_cfg.dest_width        <= pwdata[15:0];
                REG_COL_B:  r_cfg.col_base          <= pwdata[15:0];
                REG_ROW_B:  r_cfg.row_base          <= pwdata[15:0];
                REG_TRANSP: r_cfg.transparent_index <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_MODE:   prdata = {31'd0, r_cfg.compressed_mode};
            REG_WIDTH:  prdata = {16'd0, r_cfg.frame_width};
            REG_HEIGHT: prdata = {16'd0, r_cfg.frame_height};
            REG_DEST_W: prdata = {16'd0, r_cfg.dest_width};
            REG_COL_B:  prdata = {16'd0, r_cfg.col_base};
            REG_ROW_B:  prdata = {16'd0, r_cfg.row_base};
            REG_TRANSP: prdata = {24'd0, r_cfg.transparent_index};
            default:    prdata = '0;
        endcase
    end

    srd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (i_byte),
        .i_cfg    (r_cfg),
        .i_q_full (w_full),
        .o_q_push (w_push),
        .o_q_cmd  (w_push_cmd)
    );

    srd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_head_cmd),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    srd_back #(
        .ADDR_BITS (ADDR_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_empty (w_empty),
        .i_q_cmd   (w_head_cmd),
        .o_q_pop   (w_pop),
        .o_pix     (o_pix)
    );

endmodule

`default_nettype wire
